// ----- rtl/led_strip_pattern_generator_core_defines.svh -----
// Assertion macros shared by the pattern generator RTL.
`ifndef LED_STRIP_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define LED_STRIP_PATTERN_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i and held off during reset.
`define LSPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and held off during reset.
`define LSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lspg_pkg.sv -----
// Types, constants and color functions of the LED strip pattern generator.
`timescale 1ns / 1ps

package lspg_pkg;

  // Field widths.
  localparam int unsigned IdxW     = 10;
  localparam int unsigned StepW    = 8;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned LenW     = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // Strip length limits and register reset values.
  localparam logic [LenW-1:0]   MaxLeds     = 11'd1024;
  localparam logic [LenW-1:0]   LenReset    = 11'd111;
  localparam logic [ColorW-1:0] RedReset    = 8'd255;
  localparam logic [ColorW-1:0] GreenReset  = 8'd0;
  localparam logic [ColorW-1:0] BlueReset   = 8'd0;

  // Divider pipeline: quotient bits resolved per stage and stage count.
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned QuoW         = StepW;
  localparam int unsigned NumDivStages = QuoW / BitsPerStage;
  localparam int unsigned RemW         = LenW + 1;

  // Color wheel segment bounds.
  localparam logic [7:0] HueSeg1  = 8'd85;
  localparam logic [7:0] HueSeg2  = 8'd170;
  localparam logic [7:0] ColorMax = 8'd255;
  localparam logic [8:0] HueMod   = 9'd255;

  typedef enum logic [ModeW-1:0] {
    MODE_RAINBOW       = 2'd0,
    MODE_CHASE         = 2'd1,
    MODE_CHASE_RAINBOW = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EFFECT_MODE  = 3'd0,
    CFG_STRIP_LENGTH = 3'd1,
    CFG_CHASE_RED    = 3'd2,
    CFG_CHASE_GREEN  = 3'd3,
    CFG_CHASE_BLUE   = 3'd4
  } cfg_reg_e;

  // Per-pixel state carried down the pipeline.
  typedef struct packed {
    logic [RemW-1:0]   rem;
    logic [QuoW-1:0]   quo;
    logic [StepW-1:0]  step;
    logic [ColorW-1:0] chase_hue;
    logic              lit;
    logic              off;
  } pix_t;

  typedef struct packed {
    logic [ColorW-1:0] r;
    logic [ColorW-1:0] g;
    logic [ColorW-1:0] b;
  } rgb_t;

  // Index mod 3 by folding base-4 digits, since 4 is 1 mod 3.
  function automatic logic [1:0] mod3_idx(logic [IdxW-1:0] v);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]}
        + {2'b00, v[9:8]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    u = {2'b00, t[2]} + {1'b0, t[1:0]};
    return (u == 3'd3) ? 2'd0 : u[1:0];
  endfunction

  // Value mod 255 by folding the high bits onto the low byte.
  function automatic logic [7:0] mod255(logic [LenW-1:0] x);
    logic [8:0] s;
    s = {1'b0, x[7:0]} + {6'd0, x[10:8]};
    if (s >= HueMod) begin
      s = s - HueMod;
    end
    return s[7:0];
  endfunction

  // Color wheel: three segments of 85, 85 and 86 hues with linear ramps.
  function automatic rgb_t wheel(logic [7:0] hue);
    rgb_t       c;
    logic [7:0] p;
    logic [9:0] p3;
    logic [7:0] rise;
    logic [7:0] fall;
    if (hue < HueSeg1) begin
      p = hue;
    end else if (hue < HueSeg2) begin
      p = hue - HueSeg1;
    end else begin
      p = hue - HueSeg2;
    end
    p3   = {2'b00, p} + {1'b0, p, 1'b0};
    rise = p3[7:0];
    fall = ColorMax - rise;
    if (hue < HueSeg1) begin
      c.r = rise;
      c.g = fall;
      c.b = '0;
    end else if (hue < HueSeg2) begin
      c.r = fall;
      c.g = '0;
      c.b = rise;
    end else begin
      c.r = '0;
      c.g = rise;
      c.b = fall;
    end
    return c;
  endfunction

endpackage

// ----- rtl/lspg_pix_if.sv -----
// Stream interface carrying one pixel request word.
`timescale 1ns / 1ps

interface lspg_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lspg_pkg::IdxW-1:0]   led_index;
  logic [lspg_pkg::StepW-1:0]  frame_step;
  logic [lspg_pkg::PhaseW-1:0] chase_phase;

  modport source (output valid, output led_index, output frame_step, output chase_phase,
                  input ready);
  modport sink (input valid, input led_index, input frame_step, input chase_phase,
                output ready);
endinterface

// ----- rtl/lspg_rgb_if.sv -----
// Stream interface carrying one RGB color word.
`timescale 1ns / 1ps

interface lspg_rgb_if;
  logic                        valid;
  logic                        ready;
  logic [lspg_pkg::ColorW-1:0] red_level;
  logic [lspg_pkg::ColorW-1:0] green_level;
  logic [lspg_pkg::ColorW-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

// ----- rtl/lspg_div_pair.sv -----
// One divider pipeline stage resolving two quotient bits per word.
`timescale 1ns / 1ps

module lspg_div_pair (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lspg_pkg::LenW-1:0] n_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lspg_pkg::pix_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lspg_pkg::pix_t            out_data_o
);
  import lspg_pkg::*;

  logic            valid_q;
  pix_t            data_q;
  pix_t            data_d;
  logic [RemW-1:0] rem;
  logic [RemW-1:0] shl;
  logic [QuoW-1:0] quo;

  // The stage takes a word when it is empty or its word moves on.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Restoring division steps: shift, compare against the length, subtract.
  always_comb begin
    rem = in_data_i.rem;
    quo = in_data_i.quo;
    shl = '0;
    for (int b = 0; b < BitsPerStage; b++) begin
      shl = {rem[RemW-2:0], 1'b0};
      if (shl >= {1'b0, n_i}) begin
        rem = shl - {1'b0, n_i};
        quo = {quo[QuoW-2:0], 1'b1};
      end else begin
        rem = shl;
        quo = {quo[QuoW-2:0], 1'b0};
      end
    end
    data_d     = in_data_i;
    data_d.rem = rem;
    data_d.quo = quo;
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- rtl/led_strip_pattern_generator_core.sv -----
// A pixel passes the entry stage, the divider stages and the output register in order.
// One pixel per cycle unless rgb stalls; a stage advances when its successor has room.
// The rainbow spread divider resolves 2 quotient bits in each of 4 stages.
// Reset empties the pipeline and loads the documented register defaults.
`timescale 1ns / 1ps

module led_strip_pattern_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lspg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lspg_pkg::CfgDataW-1:0] cfg_wdata_i,
  lspg_pix_if.sink                      pix,
  lspg_rgb_if.source                    rgb
);
  import lspg_pkg::*;

  `include "led_strip_pattern_generator_core_defines.svh"

  mode_e             effect_mode_q;
  logic [LenW-1:0]   strip_length_q;
  logic [ColorW-1:0] chase_red_q;
  logic [ColorW-1:0] chase_green_q;
  logic [ColorW-1:0] chase_blue_q;

  logic [LenW-1:0]   n_eff;
  pix_t              s0_d;
  logic              up_ready [NumDivStages+2];
  logic              stg_valid [NumDivStages+1];
  pix_t              stg_data [NumDivStages+1];
  logic              rgb_valid_q;
  rgb_t              color_d;
  rgb_t              color_q;
  logic [7:0]        rain_hue;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_mode_q  <= MODE_RAINBOW;
      strip_length_q <= LenReset;
      chase_red_q    <= RedReset;
      chase_green_q  <= GreenReset;
      chase_blue_q   <= BlueReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EFFECT_MODE:  effect_mode_q  <= mode_e'(cfg_wdata_i[ModeW-1:0]);
        CFG_STRIP_LENGTH: strip_length_q <= cfg_wdata_i[LenW-1:0];
        CFG_CHASE_RED:    chase_red_q    <= cfg_wdata_i[ColorW-1:0];
        CFG_CHASE_GREEN:  chase_green_q  <= cfg_wdata_i[ColorW-1:0];
        CFG_CHASE_BLUE:   chase_blue_q   <= cfg_wdata_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Effective strip length: zero counts as one, long strips are clipped.
  always_comb begin
    if (strip_length_q == '0) begin
      n_eff = LenW'(1);
    end else if (strip_length_q > MaxLeds) begin
      n_eff = MaxLeds;
    end else begin
      n_eff = strip_length_q;
    end
  end

  // Entry stage: chase match, off-strip flag and the chase rainbow hue.
  always_comb begin
    s0_d.rem       = {{(RemW-IdxW){1'b0}}, pix.led_index};
    s0_d.quo       = '0;
    s0_d.step      = pix.frame_step;
    s0_d.lit       = (mod3_idx(pix.led_index) == pix.chase_phase);
    s0_d.off       = ({1'b0, pix.led_index} >= n_eff);
    s0_d.chase_hue = mod255({1'b0, pix.led_index} - {{(LenW-PhaseW){1'b0}}, pix.chase_phase}
                            + {{(LenW-StepW){1'b0}}, pix.frame_step});
  end

  assign up_ready[0] = !stg_valid[0] || up_ready[1];
  assign pix.ready   = up_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid[0] <= 1'b0;
    end else if (up_ready[0]) begin
      stg_valid[0] <= pix.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready[0] && pix.valid) begin
      stg_data[0] <= s0_d;
    end
  end

  // Divider pipeline for the rainbow spread, index * 256 / length.
  for (genvar k = 1; k <= NumDivStages; k++) begin : g_div
    lspg_div_pair u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .n_i         (n_eff),
      .in_valid_i  (stg_valid[k-1]),
      .in_ready_o  (up_ready[k]),
      .in_data_i   (stg_data[k-1]),
      .out_valid_o (stg_valid[k]),
      .out_ready_i (up_ready[k+1]),
      .out_data_o  (stg_data[k])
    );
  end

  // Color select by effect mode.
  assign rain_hue = stg_data[NumDivStages].quo + stg_data[NumDivStages].step;

  always_comb begin
    color_d = '0;
    unique case (effect_mode_q)
      MODE_RAINBOW: begin
        color_d = wheel(rain_hue);
      end
      MODE_CHASE: begin
        if (stg_data[NumDivStages].lit) begin
          color_d.r = chase_red_q;
          color_d.g = chase_green_q;
          color_d.b = chase_blue_q;
        end
      end
      MODE_CHASE_RAINBOW: begin
        if (stg_data[NumDivStages].lit) begin
          color_d = wheel(stg_data[NumDivStages].chase_hue);
        end
      end
      default: color_d = '0;
    endcase
    if (stg_data[NumDivStages].off) begin
      color_d = '0;
    end
  end

  // Output register.
  assign up_ready[NumDivStages+1] = !rgb_valid_q || rgb.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_valid_q <= 1'b0;
    end else if (up_ready[NumDivStages+1]) begin
      rgb_valid_q <= stg_valid[NumDivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready[NumDivStages+1] && stg_valid[NumDivStages]) begin
      color_q <= color_d;
    end
  end

  assign rgb.valid       = rgb_valid_q;
  assign rgb.red_level   = color_q.r;
  assign rgb.green_level = color_q.g;
  assign rgb.blue_level  = color_q.b;

  // An off-strip pixel always leaves as black.
  `LSPG_ASSERT_NEXT(a_off_is_black,
    stg_valid[NumDivStages] && up_ready[NumDivStages+1] && stg_data[NumDivStages].off,
    color_q == '0, "off-strip pixel produced a nonzero color")

  // The input stalls only when every stage and the output hold a word.
  `LSPG_ASSERT_NOW(a_stall_only_full, !pix.ready,
    stg_valid[0] && stg_valid[NumDivStages] && rgb_valid_q && !rgb.ready,
    "input stalled while the pipeline had room")

  // A result appears only after the last divider stage held a word.
  `LSPG_ASSERT_NOW(a_out_from_pipe, $rose(rgb_valid_q), $past(stg_valid[NumDivStages]),
    "result valid rose without a word in the last stage")

endmodule
